// ----- design/skl_pkg.sv -----
// ----------------------------------------------------------------------------
// skl_pkg: shared definitions for the sorted key list
// Operation and status codes, register map and the control structs that
// pass between the controller, the cell row and each cell.
// ----------------------------------------------------------------------------
package skl_pkg;

  // Default sizes of the store.
  localparam int DEPTH_DEFAULT     = 16;
  localparam int KEY_WIDTH_DEFAULT = 32;

  // Width of the request key and found key ports.
  localparam int KEY_PORT_W = 32;

  // Configuration port geometry.
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic [0:0] REG_COMPARE_SIGNED = 1'd0;

  // Operation codes.
  localparam logic [1:0] OP_ADD      = 2'd0;
  localparam logic [1:0] OP_ADD_ONCE = 2'd1;
  localparam logic [1:0] OP_SEARCH   = 2'd2;
  localparam logic [1:0] OP_DELETE   = 2'd3;

  // Status codes.
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_PRESENT   = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;

  // Command from the controller to the cell row.
  typedef struct packed {
    logic cmp_en;  // capture compare flags in every cell
    logic ins;     // insert the request key at its sorted place
    logic del;     // remove the first matching key
  } skl_req_t;

  // Per-cell control produced by the cell row.
  typedef struct packed {
    logic cmp_en;  // capture compare flags
    logic occ;     // this cell holds a stored key
    logic ins;     // insert update this cycle
    logic del;     // delete update this cycle
    logic keep;    // this cell and all cells to its left are below the key
    logic at_pos;  // this cell is the first one not below the key
  } skl_cell_ctl_t;

endpackage

// ----- design/sorted_key_list_top.sv -----
// ----------------------------------------------------------------------------
// sorted_key_list_top: sorted key store with add, add-once, search, delete
// Keeps up to DEPTH keys in ascending order in a row of cells and answers
// each request with a status, the matched key and the entry count.
// ----------------------------------------------------------------------------
//
//  Channel  | Direction | Handshake          | Payload
//  ---------+-----------+--------------------+------------------------------
//  request  | in        | in_valid/in_stall  | operation, key
//  result   | out       | out_valid/out_stall| status, found_key, entry_total
//  config   | in        | APB psel/penable   | compare_signed at address 0
//
//  A request is accepted in the idle state, all cells capture their compare
//  flags in the next cycle, and in the update state the row shifts and the
//  result register loads; no new request is taken until then. The update
//  state waits while the result register still holds a result under stall.
//  Reset empties the store at once and clears compare_signed; stored keys
//  are not cleared.
//
module sorted_key_list_top #(
  parameter int DEPTH     = skl_pkg::DEPTH_DEFAULT,
  parameter int KEY_WIDTH = skl_pkg::KEY_WIDTH_DEFAULT,
  parameter int CNT_W     = $clog2(DEPTH + 1)
) (
  input  logic                              clk,
  input  logic                              rst,
  // Configuration port.
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [skl_pkg::PADDR_W-1:0]       paddr,
  input  logic [skl_pkg::PDATA_W-1:0]       pwdata,
  output logic [skl_pkg::PDATA_W-1:0]       prdata,
  output logic                              pready,
  // Request channel.
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [1:0]                        operation,
  input  logic [skl_pkg::KEY_PORT_W-1:0]    key,
  // Result channel.
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [1:0]                        status,
  output logic [skl_pkg::KEY_PORT_W-1:0]    found_key,
  output logic [CNT_W-1:0]                  entry_total
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_UPD
  } state_t;

  state_t               state;
  logic                 compare_signed;
  logic [CNT_W-1:0]     count;
  logic [CNT_W-1:0]     count_next;
  logic [1:0]           op_q;
  logic [KEY_WIDTH-1:0] req_key;
  logic                 hit;
  logic                 full;
  logic                 upd_go;
  logic                 do_ins;
  logic                 do_del;
  logic [1:0]           status_next;
  logic                 found_next;
  logic                 cfg_wr;
  skl_pkg::skl_req_t    req;

  // Register access.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready &&
                  (paddr[skl_pkg::PADDR_W-1:2] == skl_pkg::REG_COMPARE_SIGNED);

  always_comb begin
    prdata = '0;
    if (paddr[skl_pkg::PADDR_W-1:2] == skl_pkg::REG_COMPARE_SIGNED) begin
      prdata[0] = compare_signed;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      compare_signed <= 1'b0;
    end else if (cfg_wr) begin
      compare_signed <= pwdata[0];
    end
  end

  // Update decision once the compare flags are in.
  assign full   = count == CNT_W'(DEPTH);
  assign upd_go = (state == S_UPD) && (!out_valid || !out_stall);

  always_comb begin
    do_ins      = 1'b0;
    do_del      = 1'b0;
    status_next = skl_pkg::ST_OK;
    found_next  = 1'b0;
    case (op_q)
      skl_pkg::OP_ADD: begin
        if (full) begin
          status_next = skl_pkg::ST_FULL;
        end else begin
          do_ins = 1'b1;
        end
      end
      skl_pkg::OP_ADD_ONCE: begin
        if (hit) begin
          status_next = skl_pkg::ST_PRESENT;
          found_next  = 1'b1;
        end else if (full) begin
          status_next = skl_pkg::ST_FULL;
        end else begin
          do_ins = 1'b1;
        end
      end
      skl_pkg::OP_SEARCH: begin
        if (hit) begin
          found_next = 1'b1;
        end else begin
          status_next = skl_pkg::ST_NOT_FOUND;
        end
      end
      skl_pkg::OP_DELETE: begin
        if (hit) begin
          found_next = 1'b1;
          do_del     = 1'b1;
        end else begin
          status_next = skl_pkg::ST_NOT_FOUND;
        end
      end
      default: begin
        status_next = skl_pkg::ST_OK;
      end
    endcase
  end

  always_comb begin
    count_next = count;
    if (do_ins) begin
      count_next = count + CNT_W'(1);
    end else if (do_del) begin
      count_next = count - CNT_W'(1);
    end
  end

  // Command to the cell row.
  assign req.cmp_en = state == S_CMP;
  assign req.ins    = upd_go && do_ins;
  assign req.del    = upd_go && do_del;

  skl_chain #(
    .DEPTH     (DEPTH),
    .KEY_WIDTH (KEY_WIDTH),
    .CNT_W     (CNT_W)
  ) u_chain (
    .clk            (clk),
    .req            (req),
    .count          (count),
    .compare_signed (compare_signed),
    .req_key        (req_key),
    .hit            (hit)
  );

  assign in_stall = state != S_IDLE;

  // Sequencer, entry count and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      // A taken result clears the register unless a new one loads now.
      if (out_valid && !out_stall && !upd_go) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            op_q    <= operation;
            req_key <= KEY_WIDTH'(key);
            state   <= S_CMP;
          end
        end
        S_CMP: begin
          state <= S_UPD;
        end
        S_UPD: begin
          if (upd_go) begin
            count       <= count_next;
            out_valid   <= 1'b1;
            status      <= status_next;
            found_key   <= found_next ? skl_pkg::KEY_PORT_W'(req_key) : '0;
            entry_total <= count_next;
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- design/skl_cell.sv -----
// ----------------------------------------------------------------------------
// skl_cell: one slot of the sorted key list
// Holds one key, compares it with the broadcast request key, and on an
// update keeps its key, loads the request key, or takes a neighbor's key.
// ----------------------------------------------------------------------------
module skl_cell #(
  parameter int KEY_WIDTH = skl_pkg::KEY_WIDTH_DEFAULT
) (
  input  logic                      clk,
  input  skl_pkg::skl_cell_ctl_t    ctl,
  input  logic                      compare_signed,
  input  logic [KEY_WIDTH-1:0]      req_key,
  input  logic [KEY_WIDTH-1:0]      key_left,
  input  logic [KEY_WIDTH-1:0]      key_right,
  output logic [KEY_WIDTH-1:0]      key_q,
  output logic                      lt_q,
  output logic                      eq_q
);

  logic [KEY_WIDTH-1:0] sign_flip;
  logic [KEY_WIDTH-1:0] own_ord;
  logic [KEY_WIDTH-1:0] req_ord;

  // Flipping the sign bit turns signed order into unsigned order.
  assign sign_flip = {compare_signed, {(KEY_WIDTH-1){1'b0}}};
  assign own_ord   = key_q ^ sign_flip;
  assign req_ord   = req_key ^ sign_flip;

  // Compare flags are captured in the compare cycle and used in the update.
  always_ff @(posedge clk) begin
    if (ctl.cmp_en) begin
      lt_q <= ctl.occ && (own_ord < req_ord);
      eq_q <= ctl.occ && (key_q == req_key);
    end
  end

  // Shift right on insert, shift left on delete, from the insertion point on.
  always_ff @(posedge clk) begin
    if (ctl.ins && !ctl.keep) begin
      key_q <= ctl.at_pos ? req_key : key_left;
    end else if (ctl.del && !ctl.keep) begin
      key_q <= key_right;
    end
  end

endmodule

// ----- design/skl_chain.sv -----
// ----------------------------------------------------------------------------
// skl_chain: the row of key cells
// Instantiates one cell per slot, links neighbors, and finds the insertion
// point as the end of the leading run of keys that are below the request.
// ----------------------------------------------------------------------------
module skl_chain #(
  parameter int DEPTH     = skl_pkg::DEPTH_DEFAULT,
  parameter int KEY_WIDTH = skl_pkg::KEY_WIDTH_DEFAULT,
  parameter int CNT_W     = $clog2(DEPTH + 1)
) (
  input  logic                  clk,
  input  skl_pkg::skl_req_t     req,
  input  logic [CNT_W-1:0]      count,
  input  logic                  compare_signed,
  input  logic [KEY_WIDTH-1:0]  req_key,
  output logic                  hit
);

  localparam int LVL = $clog2(DEPTH);

  logic [KEY_WIDTH-1:0] keys [DEPTH];
  logic [DEPTH-1:0]     lt;
  logic [DEPTH-1:0]     eq;
  logic [DEPTH-1:0]     pfx [LVL+1];
  logic [DEPTH-1:0]     at_pos;
  logic [DEPTH-1:0]     hit_vec;

  // Prefix AND over the below-request flags, one doubling span per level.
  assign pfx[0] = lt;
  for (genvar l = 0; l < LVL; l++) begin : g_lvl
    for (genvar i = 0; i < DEPTH; i++) begin : g_bit
      if (i >= (1 << l)) begin : g_and
        assign pfx[l+1][i] = pfx[l][i] & pfx[l][i-(1<<l)];
      end else begin : g_pass
        assign pfx[l+1][i] = pfx[l][i];
      end
    end
  end

  // The insertion point is the first cell that ends the prefix run.
  assign at_pos[0] = !pfx[LVL][0];
  for (genvar i = 1; i < DEPTH; i++) begin : g_pos
    assign at_pos[i] = !pfx[LVL][i] && pfx[LVL][i-1];
  end

  // A hit is an equal key sitting exactly at the insertion point.
  assign hit_vec = eq & at_pos;
  assign hit     = |hit_vec;

  // The cells and their neighbor links.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    skl_pkg::skl_cell_ctl_t ctl;
    logic [KEY_WIDTH-1:0]   key_left;
    logic [KEY_WIDTH-1:0]   key_right;

    assign ctl.cmp_en = req.cmp_en;
    assign ctl.occ    = CNT_W'(i) < count;
    assign ctl.ins    = req.ins;
    assign ctl.del    = req.del;
    assign ctl.keep   = pfx[LVL][i];
    assign ctl.at_pos = at_pos[i];

    if (i == 0) begin : g_first
      assign key_left = req_key;
    end else begin : g_left
      assign key_left = keys[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign key_right = keys[i];
    end else begin : g_right
      assign key_right = keys[i+1];
    end

    skl_cell #(
      .KEY_WIDTH (KEY_WIDTH)
    ) u_cell (
      .clk            (clk),
      .ctl            (ctl),
      .compare_signed (compare_signed),
      .req_key        (req_key),
      .key_left       (key_left),
      .key_right      (key_right),
      .key_q          (keys[i]),
      .lt_q           (lt[i]),
      .eq_q           (eq[i])
    );
  end

endmodule
